@@ rtl/chm_pkg.sv @@
package chm_pkg;

  localparam int ADDRESS_BITS_DEF = 16;
  localparam int OFFSET_BITS_DEF  = 6;
  localparam int LINE_COUNT_DEF   = 8;

  localparam int DATA_W    = 32;
  localparam int COUNT_W   = 16;
  localparam int SET_OUT_W = 3;

  typedef enum logic {
    MODE_DIRECT  = 1'b0,
    MODE_TWO_WAY = 1'b1
  } org_mode_t;

  // One access as seen by the hit and miss tallies.
  typedef struct packed {
    logic fire;
    logic hit;
  } tally_t;

endpackage

@@ rtl/chm_line_store.sv @@
module chm_line_store import chm_pkg::*; #(
  parameter int LINE_COUNT = LINE_COUNT_DEF,
  parameter int TAG_W      = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [TAG_W-1:0]                  cmp_tag,
  input  logic [$clog2(LINE_COUNT)-1:0]     rd_line,
  output logic [DATA_W-1:0]                 rd_data,
  output logic [LINE_COUNT-1:0]             match,
  output logic [LINE_COUNT-1:0]             valid,
  output logic [LINE_COUNT/2-1:0]           lru,
  input  logic                              wr_en,
  input  logic [$clog2(LINE_COUNT)-1:0]     wr_line,
  input  logic [TAG_W-1:0]                  wr_tag,
  input  logic [DATA_W-1:0]                 wr_data,
  input  logic                              lru_en,
  input  logic [$clog2(LINE_COUNT)-2:0]     lru_set,
  input  logic                              lru_val
);

  logic [LINE_COUNT-1:0]   valid_r;
  logic [LINE_COUNT/2-1:0] lru_r;
  logic [TAG_W-1:0]        tag_r   [LINE_COUNT];
  logic [DATA_W-1:0]       value_r [LINE_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      lru_r   <= '0;
    end else begin
      if (wr_en) begin
        valid_r[wr_line] <= 1'b1;
      end
      if (lru_en) begin
        lru_r[lru_set] <= lru_val;
      end
    end
  end

  // Tag and data are only ever read behind a valid bit, so they need no reset.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_r[wr_line]   <= wr_tag;
      value_r[wr_line] <= wr_data;
    end
  end

  always_comb begin
    for (int i = 0; i < LINE_COUNT; i++) begin
      match[i] = valid_r[i] && (tag_r[i] == cmp_tag);
    end
  end

  assign valid   = valid_r;
  assign lru     = lru_r;
  assign rd_data = value_r[rd_line];

endmodule

@@ rtl/chm_lookup.sv @@
module chm_lookup import chm_pkg::*; #(
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF,
  parameter int OFFSET_BITS  = OFFSET_BITS_DEF,
  parameter int LINE_COUNT   = LINE_COUNT_DEF,
  parameter int LINE_BITS    = $clog2(LINE_COUNT),
  parameter int TAG_W        = ADDRESS_BITS - OFFSET_BITS - LINE_BITS + 1
) (
  input  logic [ADDRESS_BITS-1:0]   addr,
  input  org_mode_t                 mode,
  input  logic [LINE_COUNT-1:0]     match,
  input  logic [LINE_COUNT-1:0]     valid,
  input  logic [LINE_COUNT/2-1:0]   lru,
  output logic [TAG_W-1:0]          cmp_tag,
  output logic                      hit,
  output logic                      way,
  output logic [LINE_BITS-1:0]      line,
  output logic [LINE_BITS-1:0]      set_idx,
  output logic [LINE_BITS-2:0]      pair_set
);

  logic [LINE_BITS-1:0] dm_set;
  logic [LINE_BITS-2:0] tw_set;
  logic [TAG_W-2:0]     dm_tag;
  logic [TAG_W-1:0]     tw_tag;
  logic [LINE_BITS-1:0] line0;
  logic [LINE_BITS-1:0] line1;

  assign dm_set   = addr[OFFSET_BITS +: LINE_BITS];
  assign tw_set   = addr[OFFSET_BITS +: LINE_BITS-1];
  assign dm_tag   = addr[ADDRESS_BITS-1 : OFFSET_BITS+LINE_BITS];
  assign tw_tag   = addr[ADDRESS_BITS-1 : OFFSET_BITS+LINE_BITS-1];
  assign line0    = {tw_set, 1'b0};
  assign line1    = {tw_set, 1'b1};
  assign pair_set = tw_set;

  // Tags are stored at the two-way width; a direct-mapped tag is zero-extended,
  // so lines left over from a mode change compare exactly.
  assign cmp_tag = (mode == MODE_TWO_WAY) ? tw_tag : {1'b0, dm_tag};

  always_comb begin
    hit     = 1'b0;
    way     = 1'b0;
    line    = dm_set;
    set_idx = dm_set;
    case (mode)
      MODE_DIRECT: begin
        hit = match[dm_set];
      end
      MODE_TWO_WAY: begin
        set_idx = {1'b0, tw_set};
        if (match[line0]) begin
          hit = 1'b1;
          way = 1'b0;
        end else if (match[line1]) begin
          hit = 1'b1;
          way = 1'b1;
        end else if (!valid[line0]) begin
          way = 1'b0;
        end else if (!valid[line1]) begin
          way = 1'b1;
        end else begin
          way = lru[tw_set];
        end
        line = {tw_set, way};
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/chm_counters.sv @@
module chm_counters import chm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  tally_t             tally,
  output logic [COUNT_W-1:0] hit_nxt,
  output logic [COUNT_W-1:0] miss_nxt
);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  logic [COUNT_W-1:0] hit_r;
  logic [COUNT_W-1:0] miss_r;

  always_comb begin
    hit_nxt  = hit_r;
    miss_nxt = miss_r;
    if (tally.fire && tally.hit && (hit_r != COUNT_MAX)) begin
      hit_nxt = hit_r + 1'b1;
    end
    if (tally.fire && !tally.hit && (miss_r != COUNT_MAX)) begin
      miss_nxt = miss_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r  <= '0;
      miss_r <= '0;
    end else begin
      hit_r  <= hit_nxt;
      miss_r <= miss_nxt;
    end
  end

endmodule

@@ rtl/cache_hit_miss_model.sv @@
// Hit/miss model of an eight-line cache that is either direct-mapped or two-way
// set associative with LRU replacement, chosen by cfg_wdata written with cfg_we.
// A request is taken in every cycle that start is high; busy is always low. Each
// request gives one result on the out_ ports, through the input register and then
// the result register, shown for a single cycle with out_valid high; the receiver
// cannot stall, so it must take every result in that cycle. Lookup, line fill, LRU
// update and the counters all settle between the input register and the result
// register, so a request sees the effect of the one before it.
// Changing the mode does not flush the lines, and the hit and miss totals
// saturate at their maximum.
module cache_hit_miss_model import chm_pkg::*; #(
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF,
  parameter int OFFSET_BITS  = OFFSET_BITS_DEF,
  parameter int LINE_COUNT   = LINE_COUNT_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [ADDRESS_BITS-1:0]  in_address,
  input  logic signed [DATA_W-1:0] in_fill_value,
  output logic                     out_valid,
  output logic                     out_hit,
  output logic                     out_way_used,
  output logic [SET_OUT_W-1:0]     out_set_number,
  output logic signed [DATA_W-1:0] out_line_data,
  output logic [COUNT_W-1:0]       out_hit_total,
  output logic [COUNT_W-1:0]       out_miss_total,
  input  logic                     cfg_we,
  input  logic                     cfg_wdata
);

  localparam int LINE_BITS = $clog2(LINE_COUNT);
  localparam int TAG_W     = ADDRESS_BITS - OFFSET_BITS - LINE_BITS + 1;

  org_mode_t                mode_r;
  logic                     req_r;
  logic [ADDRESS_BITS-1:0]  addr_r;
  logic [DATA_W-1:0]        fill_r;

  logic [TAG_W-1:0]         cmp_tag;
  logic                     hit;
  logic                     way;
  logic [LINE_BITS-1:0]     line;
  logic [LINE_BITS-1:0]     set_idx;
  logic [LINE_BITS-2:0]     pair_set;
  logic [LINE_COUNT-1:0]    match;
  logic [LINE_COUNT-1:0]    valid;
  logic [LINE_COUNT/2-1:0]  lru;
  logic [DATA_W-1:0]        rd_data;
  logic [LINE_BITS+2:0]     set_wide;
  tally_t                   tally;
  logic [COUNT_W-1:0]       hit_nxt;
  logic [COUNT_W-1:0]       miss_nxt;

  logic                     out_valid_r;
  logic                     out_hit_r;
  logic                     out_way_r;
  logic [SET_OUT_W-1:0]     out_set_r;
  logic [DATA_W-1:0]        out_data_r;
  logic [COUNT_W-1:0]       out_hit_total_r;
  logic [COUNT_W-1:0]       out_miss_total_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_DIRECT;
      req_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= org_mode_t'(cfg_wdata);
      end
      req_r       <= start;
      out_valid_r <= req_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      addr_r <= in_address;
      fill_r <= in_fill_value;
    end
  end

  chm_lookup #(
    .ADDRESS_BITS (ADDRESS_BITS),
    .OFFSET_BITS  (OFFSET_BITS),
    .LINE_COUNT   (LINE_COUNT)
  ) u_lookup (
    .addr     (addr_r),
    .mode     (mode_r),
    .match    (match),
    .valid    (valid),
    .lru      (lru),
    .cmp_tag  (cmp_tag),
    .hit      (hit),
    .way      (way),
    .line     (line),
    .set_idx  (set_idx),
    .pair_set (pair_set)
  );

  chm_line_store #(
    .LINE_COUNT (LINE_COUNT),
    .TAG_W      (TAG_W)
  ) u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmp_tag (cmp_tag),
    .rd_line (line),
    .rd_data (rd_data),
    .match   (match),
    .valid   (valid),
    .lru     (lru),
    .wr_en   (req_r && !hit),
    .wr_line (line),
    .wr_tag  (cmp_tag),
    .wr_data (fill_r),
    .lru_en  (req_r && (mode_r == MODE_TWO_WAY)),
    .lru_set (pair_set),
    .lru_val (~way)
  );

  assign tally.fire = req_r;
  assign tally.hit  = hit;

  chm_counters u_counters (
    .clk      (clk),
    .rst_n    (rst_n),
    .tally    (tally),
    .hit_nxt  (hit_nxt),
    .miss_nxt (miss_nxt)
  );

  assign set_wide = {3'b000, set_idx};

  // On a miss the line now holds the fill value.
  always_ff @(posedge clk) begin
    if (req_r) begin
      out_hit_r        <= hit;
      out_way_r        <= way;
      out_set_r        <= set_wide[SET_OUT_W-1:0];
      out_data_r       <= hit ? rd_data : fill_r;
      out_hit_total_r  <= hit_nxt;
      out_miss_total_r <= miss_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_way_used   = out_way_r;
  assign out_set_number = out_set_r;
  assign out_line_data  = out_data_r;
  assign out_hit_total  = out_hit_total_r;
  assign out_miss_total = out_miss_total_r;

endmodule

@@ rtl/chm_checker.sv @@
module chm_checker import chm_pkg::*; #(
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic [ADDRESS_BITS-1:0]  in_address,
  input logic signed [DATA_W-1:0] in_fill_value,
  input logic                     out_valid,
  input logic                     out_hit,
  input logic                     out_way_used,
  input logic [SET_OUT_W-1:0]     out_set_number,
  input logic signed [DATA_W-1:0] out_line_data,
  input logic [COUNT_W-1:0]       out_hit_total,
  input logic [COUNT_W-1:0]       out_miss_total,
  input logic                     cfg_we,
  input logic                     cfg_wdata
);

  // A result appears only for a matching earlier request on start.
  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 2))
    else $error("result without a matching request");

  // Every request taken out of reset yields its result.
  a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) ##1 rst_n |=> out_valid)
    else $error("request produced no result");

  // A reported hit has already been tallied.
  a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (out_hit_total != '0))
    else $error("hit reported with zero hit total");

  // A reported miss has already been tallied.
  a_miss_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_miss_total != '0))
    else $error("miss reported with zero miss total");

endmodule

bind cache_hit_miss_model chm_checker #(.ADDRESS_BITS(ADDRESS_BITS)) u_chm_checker (.*);

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import chm_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SHOWN_ERRORS = 30;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_REQUESTS = 125;

  typedef struct {
    logic hit;
    logic way;
    logic [SET_OUT_W-1:0] set_idx;
    logic signed [DATA_W-1:0] data;
    logic [COUNT_W-1:0] hits;
    logic [COUNT_W-1:0] misses;
  } lookup_outcome_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [15:0] in_address;
  logic signed [DATA_W-1:0] in_fill_value;
  logic out_valid;
  logic out_hit;
  logic out_way_used;
  logic [SET_OUT_W-1:0] out_set_number;
  logic signed [DATA_W-1:0] out_line_data;
  logic [COUNT_W-1:0] out_hit_total;
  logic [COUNT_W-1:0] out_miss_total;
  logic cfg_we;
  logic cfg_wdata;

  // Shadow copy of the cache contents and tallies.
  logic line_ok [8];
  logic [7:0] line_tag [8];
  logic signed [DATA_W-1:0] line_word [8];
  logic older_way [4];
  logic [COUNT_W-1:0] hit_tally;
  logic [COUNT_W-1:0] miss_tally;
  org_mode_t cache_org;

  lookup_outcome_t lookup_outcomes [$];
  int requests_sent;
  int outcomes_checked;
  int mode_writes;
  int error_count;
  int cycle_count;
  logic [7:0] tag_pool [3];

  cache_hit_miss_model dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_address    (in_address),
    .in_fill_value (in_fill_value),
    .out_valid     (out_valid),
    .out_hit       (out_hit),
    .out_way_used  (out_way_used),
    .out_set_number(out_set_number),
    .out_line_data (out_line_data),
    .out_hit_total (out_hit_total),
    .out_miss_total(out_miss_total),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, lookup_outcomes.size());
      $display("FAIL cache_hit_miss_model");
      $finish;
    end
  end

  function automatic lookup_outcome_t predict_lookup(logic [15:0] addr,
                                                     logic signed [DATA_W-1:0] fill);
    lookup_outcome_t r;
    logic [7:0] tag;
    logic [2:0] line;
    logic way;
    logic hit;
    way = 1'b0;
    if (cache_org == MODE_DIRECT) begin
      r.set_idx = addr[8:6];
      tag = {1'b0, addr[15:9]};
      line = addr[8:6];
      hit = line_ok[line] && line_tag[line] == tag;
    end else begin
      r.set_idx = {1'b0, addr[7:6]};
      tag = addr[15:8];
      if (line_ok[{addr[7:6], 1'b0}] && line_tag[{addr[7:6], 1'b0}] == tag) begin
        hit = 1'b1;
        way = 1'b0;
      end else if (line_ok[{addr[7:6], 1'b1}] && line_tag[{addr[7:6], 1'b1}] == tag) begin
        hit = 1'b1;
        way = 1'b1;
      end else begin
        hit = 1'b0;
        if (!line_ok[{addr[7:6], 1'b0}]) way = 1'b0;
        else if (!line_ok[{addr[7:6], 1'b1}]) way = 1'b1;
        else way = older_way[addr[7:6]];
      end
      line = {addr[7:6], way};
      older_way[addr[7:6]] = ~way;
    end
    if (hit) begin
      if (hit_tally != '1) hit_tally++;
    end else begin
      line_ok[line] = 1'b1;
      line_tag[line] = tag;
      line_word[line] = fill;
      if (miss_tally != '1) miss_tally++;
    end
    r.hit = hit;
    r.way = way;
    r.data = line_word[line];
    r.hits = hit_tally;
    r.misses = miss_tally;
    return r;
  endfunction

  task automatic send_request(logic [15:0] addr, logic signed [DATA_W-1:0] fill);
    @(negedge clk);
    start <= 1'b1;
    in_address <= addr;
    in_fill_value <= fill;
    do @(posedge clk); while (busy !== 1'b0);
    lookup_outcomes.push_back(predict_lookup(addr, fill));
    requests_sent++;
  endtask

  task automatic random_pause();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 55) n = 0;
    else if (r < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Stop sending, wait for every outstanding result, and let the pipeline settle.
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (lookup_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(org_mode_t m);
    drain_results();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
    cache_org = m;
    mode_writes++;
  endtask

  task automatic flag_mismatch(string field, logic [31:0] want, logic [31:0] got);
    error_count++;
    if (error_count <= SHOWN_ERRORS)
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    lookup_outcome_t w;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (lookup_outcomes.size() == 0) begin
        error_count++;
        if (error_count <= SHOWN_ERRORS)
          $display("%0t: result with no pending request, expected none, got hit=%0b set=%0d",
                   $time, out_hit, out_set_number);
      end else begin
        w = lookup_outcomes.pop_front();
        outcomes_checked++;
        if (out_hit !== w.hit) flag_mismatch("hit", w.hit, out_hit);
        if (out_way_used !== w.way) flag_mismatch("way_used", w.way, out_way_used);
        if (out_set_number !== w.set_idx) flag_mismatch("set_number", w.set_idx, out_set_number);
        if (out_line_data !== w.data) flag_mismatch("line_data", w.data, out_line_data);
        if (out_hit_total !== w.hits) flag_mismatch("hit_total", w.hits, out_hit_total);
        if (out_miss_total !== w.misses) flag_mismatch("miss_total", w.misses, out_miss_total);
      end
    end
  end

  task automatic test_direct_fill_and_evict();
    send_request(16'h0000, 32'sh8000_0000);
    send_request(16'h003F, 32'sh0000_0001);
    send_request(16'hFFFF, 32'sh7FFF_FFFF);
    send_request(16'hFFC0, 32'sh0000_0000);
    // Same set, other tag: the only line of set 0 is replaced.
    send_request(16'h0200, -32'sd1);
    send_request(16'h0000, 32'sh5A5A_5A5A);
  endtask

  task automatic test_two_way_lru();
    write_mode(MODE_TWO_WAY);
    send_request(16'h0040, 32'sh1111_1111);
    send_request(16'h1040, 32'sh2222_2222);
    send_request(16'h0040, 32'sh3333_3333);
    // Both ways valid: the way not touched last is the victim each time.
    send_request(16'h2040, 32'sh4444_4444);
    send_request(16'h1040, 32'sh5555_5555);
    send_request(16'h2070, 32'sh6666_6666);
    send_request(16'hFFFF, 32'sh7FFF_FFFF);
  endtask

  task automatic test_mode_switch_keeps_lines();
    // A line filled direct-mapped is found again under the two-way split.
    send_request(16'h0000, 32'sh0BAD_0BAD);
    write_mode(MODE_DIRECT);
    send_request(16'h40C0, 32'sh0123_4567);
    send_request(16'h2080, 32'sh7654_3210);
    write_mode(MODE_TWO_WAY);
    send_request(16'h0000, 32'sh0F0F_0F0F);
    send_request(16'h40C0, 32'sh1357_9BDF);
  endtask

  function automatic logic [15:0] random_address();
    if ($urandom_range(0, 9) == 0) return 16'($urandom_range(0, 65535));
    return {tag_pool[$urandom_range(0, 2)], 8'($urandom_range(0, 255))};
  endfunction

  function automatic logic signed [DATA_W-1:0] random_fill();
    case ($urandom_range(0, 15))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_random_traffic();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_mode((p % 2 == 0) ? MODE_DIRECT : MODE_TWO_WAY);
      for (int t = 0; t < 3; t++) tag_pool[t] = 8'($urandom_range(0, 255));
      if (p == 1) tag_pool[0] = 8'hFF;
      if (p == 2) tag_pool[0] = 8'h00;
      for (int i = 0; i < PHASE_REQUESTS; i++) begin
        send_request(random_address(), random_fill());
        if (p == 3 && i == PHASE_REQUESTS / 2) drain_results();
        // The first stretch of each phase runs back to back.
        else if (i >= 30) random_pause();
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_address = '0;
    in_fill_value = '0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    cycle_count = 0;
    requests_sent = 0;
    outcomes_checked = 0;
    mode_writes = 0;
    error_count = 0;
    hit_tally = '0;
    miss_tally = '0;
    cache_org = MODE_DIRECT;
    for (int i = 0; i < 8; i++) begin
      line_ok[i] = 1'b0;
      line_tag[i] = '0;
      line_word[i] = '0;
    end
    for (int i = 0; i < 4; i++) older_way[i] = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_direct_fill_and_evict();
    test_two_way_lru();
    test_mode_switch_keeps_lines();
    test_random_traffic();

    drain_results();
    repeat (8) @(posedge clk);
    $display("Covered %0d lookups in both organizations over %0d mode writes,", requests_sent,
             mode_writes);
    $display("with fills, evictions and lines kept across mode changes; %0d results compared.",
             outcomes_checked);
    if (error_count == 0) begin
      $display("PASS cache_hit_miss_model");
    end else begin
      $display("FAIL cache_hit_miss_model");
    end
    $finish;
  end

endmodule
